### hw/rtl/bgd_pkg.sv
// bgd_pkg: shared types and constants for the button group debouncer.
// Used by bgd_cfg_regs, bgd_core and button_group_debouncer; no dependencies.

package bgd_pkg;

   // Number of button lines handled in parallel
   localparam int unsigned BTN_COUNT  = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CFG_W      = 16;
   localparam int unsigned CSR_IDX_W  = 2;

   // Byte-padded stream payload widths
   localparam int unsigned REQ_DATA_W = ((TIME_W + BTN_COUNT + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((3 * BTN_COUNT + 7) / 8) * 8;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUTTON_MASK   = 2'd0,
      CSR_POLL_INTERVAL = 2'd1,
      CSR_DEBOUNCE_TIME = 2'd2
   } csr_idx_type;

   // Reset values of the configuration registers
   localparam logic [CFG_W-1:0] RST_BUTTON_MASK   = 16'hFFFF;
   localparam logic [CFG_W-1:0] RST_POLL_INTERVAL = 16'd5;
   localparam logic [CFG_W-1:0] RST_DEBOUNCE_TIME = 16'd20;

   typedef logic [BTN_COUNT-1:0] btn_vec_type;

   // Configuration seen by the core
   typedef struct packed {
      btn_vec_type      button_mask;
      logic [CFG_W-1:0] poll_interval_ms;
      logic [CFG_W-1:0] debounce_time_ms;
   } cfg_type;

   // One poll result
   typedef struct packed {
      logic        event_valid;
      btn_vec_type pressed_mask;
      btn_vec_type released_mask;
      btn_vec_type held_mask;
   } result_type;

endpackage

### hw/rtl/button_group_debouncer.sv
// button_group_debouncer: top level with input register, core and result register.
// Depends on bgd_pkg, bgd_cfg_regs and bgd_core.
//
//   channel | direction | payload
//   req_    | in        | tdata: now_ms[31:0], gpio_sample[47:32]; tuser: read_ok
//   rsp_    | out       | tdata: pressed[15:0], released[31:16], held[47:32];
//           |           | tuser: event_valid
//   csr_    | in        | index, 16-bit data, write enable
//
// Beats pass the input and result registers; one per cycle if rsp_tready is high.
// The state update of one poll is a single compare/subtract layer between the
// input register and the result register, so successive polls follow back to back.
// Synchronous active-high reset clears the stage valids, resets state and config.
// A stall on rsp_tready holds the result; the input register still takes one beat.

module button_group_debouncer (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: now_ms [31:0], gpio_sample [47:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bgd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: read_ok [0]
   input  logic                               req_tuser,
   // rsp_tdata: pressed_mask [15:0], released_mask [31:16], held_mask [47:32]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bgd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: event_valid [0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [bgd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgd_pkg::CFG_W-1:0]          csr_wdata
);

   bgd_pkg::cfg_type     cfg;
   bgd_pkg::result_type  core_result;
   bgd_pkg::result_type  rsp_ff;

   logic                             in_valid_ff;
   logic [bgd_pkg::TIME_W-1:0]       in_now_ff;
   bgd_pkg::btn_vec_type             in_sample_ff;
   logic                             in_ok_ff;
   logic                             out_valid_ff;
   logic                             advance;
   logic                             step;

   bgd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the pipeline when the result register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_now_ff    <= req_tdata[bgd_pkg::TIME_W-1:0];
         in_sample_ff <= req_tdata[bgd_pkg::TIME_W +: bgd_pkg::BTN_COUNT];
         in_ok_ff     <= req_tuser;
      end
   end

   bgd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .now_ms      (in_now_ff),
      .gpio_sample (in_sample_ff),
      .read_ok     (in_ok_ff),
      .cfg         (cfg),
      .result      (core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_ff.event_valid;
   assign rsp_tdata  = bgd_pkg::RSP_DATA_W'({rsp_ff.held_mask, rsp_ff.released_mask,
                                             rsp_ff.pressed_mask});

   // Press and release never report the same line at once
   a_edge_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_ff.pressed_mask & rsp_ff.released_mask) == '0))
      else $error("line both pressed and released");

   // A new press is always part of the held set
   a_pressed_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_ff.pressed_mask & ~rsp_ff.held_mask) == '0))
      else $error("pressed line not held");

   // A skipped or unsettled poll carries empty masks
   a_invalid_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_ff.event_valid) |->
         (rsp_ff.pressed_mask == '0 && rsp_ff.released_mask == '0 &&
          rsp_ff.held_mask == '0))
      else $error("masks set on an invalid event");

   // A beat accepted while the output stalls must stay in the input register
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("input beat lost under stall");

endmodule

### hw/rtl/bgd_cfg_regs.sv
// bgd_cfg_regs: configuration register file of the button group debouncer.
// Depends on bgd_pkg for register indexes, reset values and cfg_type.

module bgd_cfg_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bgd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bgd_pkg::CFG_W-1:0]      csr_wdata,
   output bgd_pkg::cfg_type               cfg
);

   bgd_pkg::cfg_type cfg_ff;
   bgd_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes drop the beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bgd_pkg::csr_idx_type'(csr_index))
            bgd_pkg::CSR_BUTTON_MASK:
               cfg_in.button_mask = csr_wdata[bgd_pkg::BTN_COUNT-1:0];
            bgd_pkg::CSR_POLL_INTERVAL: cfg_in.poll_interval_ms = csr_wdata;
            bgd_pkg::CSR_DEBOUNCE_TIME: cfg_in.debounce_time_ms = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_mask      <= bgd_pkg::RST_BUTTON_MASK[bgd_pkg::BTN_COUNT-1:0];
         cfg_ff.poll_interval_ms <= bgd_pkg::RST_POLL_INTERVAL;
         cfg_ff.debounce_time_ms <= bgd_pkg::RST_DEBOUNCE_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/bgd_core.sv
// bgd_core: poll gating, settle timer and debounced state with edge detection.
// Depends on bgd_pkg for cfg_type, result_type and widths.

module bgd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [bgd_pkg::TIME_W-1:0]    now_ms,
   input  bgd_pkg::btn_vec_type          gpio_sample,
   input  logic                          read_ok,
   input  bgd_pkg::cfg_type              cfg,
   output bgd_pkg::result_type           result
);

   logic [bgd_pkg::TIME_W-1:0] last_poll_ff, last_poll_in;
   logic [bgd_pkg::TIME_W-1:0] last_change_ff, last_change_in;
   bgd_pkg::btn_vec_type       raw_ff, raw_in;
   bgd_pkg::btn_vec_type       stable_ff, stable_in;

   logic [bgd_pkg::TIME_W-1:0] poll_age;
   logic [bgd_pkg::TIME_W-1:0] settle_age;
   logic                       poll_due;
   logic                       settled;
   logic                       raw_changed;
   bgd_pkg::btn_vec_type       fresh;
   bgd_pkg::btn_vec_type       old_down;
   bgd_pkg::btn_vec_type       new_down;

   // Gate the poll by wrapping elapsed time
   assign poll_age = now_ms - last_poll_ff;
   assign poll_due = poll_age >= {{(bgd_pkg::TIME_W-bgd_pkg::CFG_W){1'b0}},
                                  cfg.poll_interval_ms};

   // Force unused lines high and detect a change of the raw vector
   assign fresh       = gpio_sample | ~cfg.button_mask;
   assign raw_changed = fresh != raw_ff;

   // A change restarts the timer, so the age is zero then
   assign settle_age = raw_changed ? '0 : (now_ms - last_change_ff);
   assign settled    = settle_age >= {{(bgd_pkg::TIME_W-bgd_pkg::CFG_W){1'b0}},
                                      cfg.debounce_time_ms};

   assign old_down = ~stable_ff & cfg.button_mask;
   assign new_down = ~fresh & cfg.button_mask;

   // Next state and result of this beat
   always_comb begin
      last_poll_in   = last_poll_ff;
      last_change_in = last_change_ff;
      raw_in         = raw_ff;
      stable_in      = stable_ff;
      result         = '0;
      if (poll_due) begin
         last_poll_in = now_ms;
         if (read_ok) begin
            raw_in = fresh;
            if (raw_changed) begin
               last_change_in = now_ms;
            end
            if (settled) begin
               stable_in            = fresh;
               result.event_valid   = 1'b1;
               result.pressed_mask  = new_down & ~old_down;
               result.released_mask = old_down & ~new_down;
               result.held_mask     = new_down;
            end
         end
      end
   end

   // Commit state only on a beat that moves through the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         last_poll_ff   <= '0;
         last_change_ff <= '0;
         raw_ff         <= '1;
         stable_ff      <= '1;
      end else if (step) begin
         last_poll_ff   <= last_poll_in;
         last_change_ff <= last_change_in;
         raw_ff         <= raw_in;
         stable_ff      <= stable_in;
      end
   end

   // State holds between beats
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(raw_ff) && $stable(stable_ff) && $stable(last_poll_ff)))
      else $error("debouncer state moved without a beat");

   // The stable vector only ever takes a value the raw vector held
   a_stable_from_raw: assert property (@(posedge clock) disable iff (reset)
      (step && result.event_valid) |=> (stable_ff == raw_ff))
      else $error("stable vector differs from raw vector after a settled poll");

endmodule
